### sv/ost_pkg.sv
// Shared types, constants and lookup functions for the octahedron sphere tessellator.
// No dependencies.
package ost_pkg;

  localparam int unsigned CoordW = 16;
  localparam logic signed [CoordW-1:0] OneQ14 = 16'sd16384;
  localparam int unsigned DivSteps = 16;
  // Deepest subdivision; the 13-bit index and 3-bit depth register are sized for it.
  localparam int unsigned MaxDepth = 5;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec3_t;

  // One beat travelling down the divider row.
  typedef struct packed {
    logic        vld;
    logic [23:0] rem;
    logic [15:0] low;
    logic [15:0] quo;
    logic        neg;
    logic [1:0]  comp;
  } div_beat_t;

  function automatic vec3_t corner(input logic [2:0] code);
    vec3_t v;
    v = '{x: '0, y: '0, z: '0};
    case (code)
      3'd0: v.z = OneQ14;
      3'd1: v.x = OneQ14;
      3'd2: v.y = OneQ14;
      3'd3: v.x = -OneQ14;
      3'd4: v.y = -OneQ14;
      3'd5: v.z = -OneQ14;
      default: v = '{x: '0, y: '0, z: '0};
    endcase
    return v;
  endfunction

  // Corner codes of face f, vertex k (a, b, c).
  function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] k);
    logic [8:0] row;
    row = '0;
    case (f)
      3'd0: row = {3'd0, 3'd1, 3'd2};
      3'd1: row = {3'd0, 3'd2, 3'd3};
      3'd2: row = {3'd0, 3'd3, 3'd4};
      3'd3: row = {3'd0, 3'd4, 3'd1};
      3'd4: row = {3'd5, 3'd2, 3'd1};
      3'd5: row = {3'd5, 3'd3, 3'd2};
      3'd6: row = {3'd5, 3'd4, 3'd3};
      3'd7: row = {3'd5, 3'd1, 3'd4};
      default: row = '0;
    endcase
    case (k)
      2'd0: return row[8:6];
      2'd1: return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

endpackage

### sv/ost_div_cell.sv
// One restoring-division step cell: one quotient bit per beat, registered.
// Depends on ost_pkg.
module ost_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ost_pkg::div_beat_t d_in,
  input  logic [23:0]       dvs,
  output ost_pkg::div_beat_t d_out
);
  import ost_pkg::*;

  logic [24:0] r2;
  logic        ge;
  div_beat_t   beat_nxt;
  div_beat_t   beat_r;

  always_comb begin
    r2 = {d_in.rem, d_in.low[15]};
    ge = (r2 >= {1'b0, dvs});
    beat_nxt = d_in;
    beat_nxt.rem = ge ? 24'(r2 - {1'b0, dvs}) : r2[23:0];
    beat_nxt.low = {d_in.low[14:0], 1'b0};
    beat_nxt.quo = {d_in.quo[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= d_in.vld;
    end
    beat_r.rem  <= beat_nxt.rem;
    beat_r.low  <= beat_nxt.low;
    beat_r.quo  <= beat_nxt.quo;
    beat_r.neg  <= beat_nxt.neg;
    beat_r.comp <= beat_nxt.comp;
  end

  assign d_out = beat_r;
endmodule

### sv/ost_mid.sv
// Normalized midpoint unit: sum, squared length, iterative square root, divider row.
// Depends on ost_pkg and ost_div_cell.
module ost_mid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ost_pkg::vec3_t p,
  input  ost_pkg::vec3_t q,
  output logic          done,
  output ost_pkg::vec3_t r
);
  import ost_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_SQ   = 5'b00010,
    M_ROOT = 5'b00100,
    M_DIV  = 5'b01000,
    M_DONE = 5'b10000
  } mst_t;

  mst_t st_r, st_nxt;
  logic signed [16:0] s_r [3];
  logic [31:0] len2_r;
  logic [47:0] v_r;
  logic [23:0] rt_r;
  logic [24:0] rm_r;
  logic [4:0]  cnt_r;
  logic [1:0]  fc_r;
  logic [1:0]  cc_r;
  vec3_t       res_r;

  logic signed [16:0] s_sel;
  logic signed [33:0] sq;
  logic [26:0] rm2, trial;
  logic        rge;
  logic [16:0] mag;
  logic [37:0] num;
  div_beat_t   feed;
  div_beat_t   chain [DivSteps+1];
  logic [15:0] qsat;
  logic signed [15:0] qval;

  always_comb begin
    s_sel = s_r[cnt_r[1:0]];
    sq    = s_sel * s_sel;
    rm2   = {rm_r, v_r[47:46]};
    trial = {1'b0, rt_r, 2'b01};
    rge   = (rm2 >= trial);
    mag   = s_r[fc_r][16] ? 17'(-s_r[fc_r]) : 17'(s_r[fc_r]);
    num   = {mag[15:0], 22'b0} + 38'(rt_r >> 1);
    feed.vld  = (st_r == M_DIV) && (fc_r != 2'd3);
    feed.rem  = 24'(num[37:16]);
    feed.low  = num[15:0];
    feed.quo  = '0;
    feed.neg  = s_r[fc_r][16];
    feed.comp = fc_r;
    qsat = (chain[DivSteps].quo > 16'd16384) ? 16'd16384 : chain[DivSteps].quo;
    qval = chain[DivSteps].neg ? -$signed(qsat) : $signed(qsat);
  end

  assign chain[0] = feed;

  for (genvar i = 0; i < DivSteps; i++) begin : g_row
    ost_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (chain[i]),
      .dvs  (rt_r),
      .d_out(chain[i+1])
    );
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      M_IDLE: if (start) st_nxt = M_SQ;
      M_SQ:   if (cnt_r == 5'd2) st_nxt = M_ROOT;
      M_ROOT: if (cnt_r == 5'd23) st_nxt = M_DIV;
      M_DIV: begin
        if (rt_r == '0) st_nxt = M_DONE;
        else if (chain[DivSteps].vld && cc_r == 2'd2) st_nxt = M_DONE;
      end
      M_DONE: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= M_IDLE;
      cnt_r <= '0;
      fc_r  <= '0;
      cc_r  <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        M_IDLE: begin
          cnt_r <= '0;
          fc_r  <= '0;
          cc_r  <= '0;
        end
        M_SQ:   cnt_r <= (cnt_r == 5'd2) ? 5'd0 : cnt_r + 5'd1;
        M_ROOT: cnt_r <= cnt_r + 5'd1;
        M_DIV: begin
          if (fc_r != 2'd3) fc_r <= fc_r + 2'd1;
          if (chain[DivSteps].vld) cc_r <= cc_r + 2'd1;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      M_IDLE: begin
        s_r[0] <= 17'(p.x) + 17'(q.x);
        s_r[1] <= 17'(p.y) + 17'(q.y);
        s_r[2] <= 17'(p.z) + 17'(q.z);
        len2_r <= '0;
        res_r  <= '{x: '0, y: '0, z: '0};
      end
      M_SQ: begin
        len2_r <= len2_r + 32'(sq);
        if (cnt_r == 5'd2) begin
          v_r  <= {len2_r + 32'(sq), 16'b0};
          rt_r <= '0;
          rm_r <= '0;
        end
      end
      M_ROOT: begin
        v_r  <= {v_r[45:0], 2'b00};
        rt_r <= {rt_r[22:0], rge};
        rm_r <= rge ? 25'(rm2 - trial) : rm2[24:0];
      end
      M_DIV: begin
        if (chain[DivSteps].vld) begin
          case (chain[DivSteps].comp)
            2'd0: res_r.x <= qval;
            2'd1: res_r.y <= qval;
            default: res_r.z <= qval;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign done = (st_r == M_DONE);
  assign r    = res_r;

  property p_div_done;
    @(posedge clk) disable iff (!rst_n)
      (st_r == M_DONE) |-> (rt_r == '0 || cc_r == 2'd3);
  endproperty
  a_div_done: assert property (p_div_done) else $error("midpoint done early");

  property p_feed_only_div;
    @(posedge clk) disable iff (!rst_n) feed.vld |-> (st_r == M_DIV);
  endproperty
  a_feed_only_div: assert property (p_feed_only_div) else $error("stray feed");

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) (st_r == M_IDLE && start) |=> (st_r == M_SQ);
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("start lost");
endmodule

### sv/octahedron_sphere_tessellator.sv
// Top level: APB config, level sequencer over a shared midpoint unit, output register.
// Depends on ost_pkg and ost_mid.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | in_triangle_index[12:0]
//  out_    | out | out_valid / out_ready| out_ax..out_cz (Q1.14), out_index_error
//  cfg_    | in  | APB write, pready=1  | depth at byte 0
//
// Timing: each level runs three midpoints one after another through the shared
// unit; a midpoint does 3 squares, 24 root steps and 3 beats through the
// 16-cell divider row.
// Reset (rst_n low, synchronous) clears depth to 0 and empties the output.
// A finished beat waits in the output register; the next item is accepted
// while it waits, and the sequencer stalls at its end only if still full.
module octahedron_sphere_tessellator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [12:0]        in_triangle_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_ax,
  output logic signed [15:0] out_ay,
  output logic signed [15:0] out_az,
  output logic signed [15:0] out_bx,
  output logic signed [15:0] out_by,
  output logic signed [15:0] out_bz,
  output logic signed [15:0] out_cx,
  output logic signed [15:0] out_cy,
  output logic signed [15:0] out_cz,
  output logic               out_index_error,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import ost_pkg::*;

  localparam logic [3:0] MaxD = 4'(MaxDepth);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_START = 5'b00010,
    T_WAIT  = 5'b00100,
    T_STEP  = 5'b01000,
    T_FIN   = 5'b10000
  } tst_t;

  tst_t st_r, st_nxt;
  logic [2:0]  depth_r;
  logic [12:0] idx_r;
  logic [3:0]  lvl_r;
  logic [1:0]  mi_r;
  logic        err_r;
  vec3_t a_r, b_r, c_r, ab_r, ac_r, cb_r;
  logic        ov_r;
  vec3_t oa_r, ob_r, oc_r;
  logic        oe_r;

  logic [3:0]  d_cl;
  logic [12:0] face_sh;
  logic        idx_err;
  logic [12:0] dig_sh;
  logic [1:0]  digit;
  logic        out_free;
  logic        mid_start, mid_done;
  vec3_t       mid_p, mid_q, mid_r;

  // config port: single register at byte 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {29'b0, depth_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      depth_r <= cfg_pwdata[2:0];
    end
  end

  always_comb begin
    d_cl    = ({1'b0, depth_r} > MaxD) ? MaxD : {1'b0, depth_r};
    face_sh = in_triangle_index >> {d_cl, 1'b0};
    idx_err = (face_sh >> 3) != '0;
    dig_sh  = idx_r >> {lvl_r - 4'd1, 1'b0};
    digit   = dig_sh[1:0];
    out_free = !ov_r || out_ready;
    mid_start = (st_r == T_START);
    // mi 0: ab, 1: ac, 2: cb
    mid_p = (mi_r == 2'd2) ? c_r : a_r;
    mid_q = (mi_r == 2'd1) ? c_r : b_r;
  end

  assign in_ready = (st_r == T_IDLE);

  ost_mid u_mid (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mid_start),
    .p    (mid_p),
    .q    (mid_q),
    .done (mid_done),
    .r    (mid_r)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE:  if (in_valid) st_nxt = (idx_err || d_cl == '0) ? T_FIN : T_START;
      T_START: st_nxt = T_WAIT;
      T_WAIT:  if (mid_done) st_nxt = (mi_r == 2'd2) ? T_STEP : T_START;
      T_STEP:  st_nxt = (lvl_r == 4'd1) ? T_FIN : T_START;
      T_FIN:   if (out_free) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      mi_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == T_WAIT && mid_done) mi_r <= (mi_r == 2'd2) ? 2'd0 : mi_r + 2'd1;
      if (st_r == T_FIN && out_free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // vertex datapath
  always_ff @(posedge clk) begin
    case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          idx_r <= in_triangle_index;
          lvl_r <= d_cl;
          err_r <= idx_err;
          a_r   <= corner(face_corner(face_sh[2:0], 2'd0));
          b_r   <= corner(face_corner(face_sh[2:0], 2'd1));
          c_r   <= corner(face_corner(face_sh[2:0], 2'd2));
        end
      end
      T_WAIT: begin
        if (mid_done) begin
          case (mi_r)
            2'd0: ab_r <= mid_r;
            2'd1: ac_r <= mid_r;
            default: cb_r <= mid_r;
          endcase
        end
      end
      T_STEP: begin
        lvl_r <= lvl_r - 4'd1;
        case (digit)
          2'd0: begin a_r <= a_r;  b_r <= ab_r; c_r <= ac_r; end
          2'd1: begin a_r <= c_r;  b_r <= ac_r; c_r <= cb_r; end
          2'd2: begin a_r <= b_r;  b_r <= cb_r; c_r <= ab_r; end
          default: begin a_r <= cb_r; b_r <= ac_r; c_r <= ab_r; end
        endcase
      end
      T_FIN: begin
        if (out_free) begin
          oe_r <= err_r;
          oa_r <= err_r ? '0 : a_r;
          ob_r <= err_r ? '0 : b_r;
          oc_r <= err_r ? '0 : c_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_ax          = oa_r.x;
  assign out_ay          = oa_r.y;
  assign out_az          = oa_r.z;
  assign out_bx          = ob_r.x;
  assign out_by          = ob_r.y;
  assign out_bz          = ob_r.z;
  assign out_cx          = oc_r.x;
  assign out_cy          = oc_r.y;
  assign out_cz          = oc_r.z;
  assign out_index_error = oe_r;

  property p_err_zero;
    @(posedge clk) disable iff (!rst_n)
      (ov_r && oe_r) |-> (oa_r == '0 && ob_r == '0 && oc_r == '0);
  endproperty
  a_err_zero: assert property (p_err_zero) else $error("error beat not zeroed");

  property p_range;
    @(posedge clk) disable iff (!rst_n)
      ov_r |-> (out_ax <= OneQ14 && out_ax >= -OneQ14 &&
                out_cz <= OneQ14 && out_cz >= -OneQ14);
  endproperty
  a_range: assert property (p_range) else $error("coordinate out of range");

  property p_accept_busy;
    @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready;
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("ready after accept");
endmodule

### test/octahedron_sphere_tessellator_tb.sv
// Testbench for octahedron_sphere_tessellator: table-driven directed beats, then random
// phases at each depth, checked against hand-written triangles or a local triangle predictor.
// Depends on ost_pkg and the octahedron_sphere_tessellator RTL.
`timescale 1ns / 1ps

module octahedron_sphere_tessellator_tb;
  import ost_pkg::*;

  localparam int Q14 = 16384;
  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 800;

  typedef struct {
    vec3_t a, b, c;
    logic  err;
  } tri_t;

  typedef struct {
    int   depth;
    int   idx;
    bit   typed;
    tri_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [12:0] in_triangle_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_ax, out_ay, out_az, out_bx, out_by, out_bz, out_cx, out_cy, out_cz;
  logic out_index_error;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  octahedron_sphere_tessellator i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Testbench copy of the depth register; written alongside each APB write.
  logic [2:0] depth_reg = '0;
  tri_t       tri_q[$];     // triangles still owed by the block
  int         errors = 0;
  bit         sink_steady = 1'b0;
  row_t       rows[$];

  // ---------------------------------------------------------------- predictor
  function automatic vec3_t corner_vec(int code);
    vec3_t v;
    v = '{x: 16'sd0, y: 16'sd0, z: 16'sd0};
    case (code)
      0: v.z = Q14;
      1: v.x = Q14;
      2: v.y = Q14;
      3: v.x = -Q14;
      4: v.y = -Q14;
      default: v.z = -Q14;
    endcase
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round(s * 2^22 / len) on the magnitude, ties away, clipped to 1.0
  function automatic logic signed [15:0] scale_coord(longint s, longint unsigned len);
    longint unsigned mag, q;
    mag = (s < 0) ? -s : s;
    q = ((mag << 22) + (len >> 1)) / len;
    if (q > Q14) q = Q14;
    return (s < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic vec3_t sphere_mid(vec3_t p, vec3_t q);
    longint sx, sy, sz;
    longint unsigned len;
    vec3_t r;
    sx = longint'(p.x) + longint'(q.x);
    sy = longint'(p.y) + longint'(q.y);
    sz = longint'(p.z) + longint'(q.z);
    len = int_sqrt(longint'(sx * sx + sy * sy + sz * sz) << 16);
    r = '{x: 16'sd0, y: 16'sd0, z: 16'sd0};
    if (len == 0) return r;  // degenerate sum maps to the origin
    r.x = scale_coord(sx, len);
    r.y = scale_coord(sy, len);
    r.z = scale_coord(sz, len);
    return r;
  endfunction

  function automatic tri_t leaf_triangle(logic [2:0] dreg, logic [12:0] idx);
    int face_code[8][3] = '{'{0,1,2}, '{0,2,3}, '{0,3,4}, '{0,4,1},
                            '{5,2,1}, '{5,3,2}, '{5,4,3}, '{5,1,4}};
    int d, face, digit;
    vec3_t ab, ac, cb;
    tri_t t;
    d = (dreg > 5) ? 5 : dreg;   // depth clamps at MAX_DEPTH
    t.err = 1'b0;
    if (int'(idx) >= (8 << (2 * d))) begin
      t.a = '0; t.b = '0; t.c = '0; t.err = 1'b1;
      return t;
    end
    face = (idx >> (2 * d)) & 7;
    t.a = corner_vec(face_code[face][0]);
    t.b = corner_vec(face_code[face][1]);
    t.c = corner_vec(face_code[face][2]);
    for (int lvl = d; lvl > 0; lvl--) begin
      digit = (idx >> (2 * (lvl - 1))) & 3;
      ab = sphere_mid(t.a, t.b);
      ac = sphere_mid(t.a, t.c);
      cb = sphere_mid(t.c, t.b);
      case (digit)
        0: begin t.b = ab; t.c = ac; end
        1: begin t.a = t.c; t.b = ac; t.c = cb; end
        2: begin t.a = t.b; t.b = cb; t.c = ab; end
        default: begin t.a = cb; t.b = ac; t.c = ab; end
      endcase
    end
    return t;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic write_depth(logic [2:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    depth_reg = value;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Sender pause: let every owed triangle come back, then the block settle.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tri_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(logic [12:0] idx, bit steady, bit typed, tri_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_triangle_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tri_q.push_back(typed ? want : leaf_triangle(depth_reg, idx));
    @(negedge clk);
  endtask

  task automatic goto_depth(logic [2:0] d);
    drain_all();
    write_depth(d);
    @(negedge clk);
  endtask

  function automatic void add_row(int d, int idx, bit typed, tri_t want);
    rows.push_back('{depth: d, idx: idx, typed: typed, want: want});
  endfunction

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    tri_t want;
    logic [15:0] got_f[10], want_f[10];
    string names[10] = '{"ax","ay","az","bx","by","bz","cx","cy","cz","index_error"};
    if (rst_n && out_valid && out_ready) begin
      if (tri_q.size() == 0) begin
        $error("triangle beat with nothing owed");
        errors++;
      end else begin
        want = tri_q.pop_front();
        got_f = '{out_ax, out_ay, out_az, out_bx, out_by, out_bz, out_cx, out_cy, out_cz,
                  16'(out_index_error)};
        want_f = '{want.a.x, want.a.y, want.a.z, want.b.x, want.b.y, want.b.z,
                   want.c.x, want.c.y, want.c.z, 16'(want.err)};
        for (int k = 0; k < 10; k++)
          if (got_f[k] !== want_f[k]) begin
            $error("%s: expected %0d, got %0d", names[k],
                   $signed(want_f[k]), $signed(got_f[k]));
            errors++;
          end
      end
    end
  end

  // Result side: random stall per beat, with stretches of none.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) sink_steady = ~sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Watchdog: cycles without any beat or register write.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle = 0;
      else
        idle++;
      if (idle >= WatchLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchLimit);
        $display("** octahedron_sphere_tessellator: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    tri_t err_tri, none;
    int phase_depth[11] = '{3, 0, 6, 1, 4, 2, 7, 5, 0, 1, 2};
    int phase_items[11] = '{150, 300, 60, 250, 100, 180, 60, 60, 300, 250, 170};
    int count;
    bit steady;
    logic [12:0] idx;

    err_tri = '{a: '0, b: '0, c: '0, err: 1'b1};
    none = err_tri;

    // Directed: faces at depth 0, each child digit, range edges, clamped depths.
    add_row(0, 0, 1, '{a: '{16'sd0, 16'sd0, 16'sd16384}, b: '{16'sd16384, 16'sd0, 16'sd0},
                       c: '{16'sd0, 16'sd16384, 16'sd0}, err: 1'b0});
    for (int f = 1; f < 8; f++)
      if (f == 4)
        add_row(0, 4, 1, '{a: '{16'sd0, 16'sd0, -16'sd16384}, b: '{16'sd0, 16'sd16384, 16'sd0},
                           c: '{16'sd16384, 16'sd0, 16'sd0}, err: 1'b0});
      else
        add_row(0, f, 0, none);
    add_row(0, 8, 1, err_tri);        // first out-of-range index
    add_row(0, 8191, 1, err_tri);     // all index bits set
    for (int k = 0; k < 4; k++) add_row(1, k, 0, none);
    add_row(1, 31, 0, none);
    add_row(1, 32, 1, err_tri);
    add_row(5, 0, 0, none);
    add_row(5, 8191, 0, none);
    add_row(5, 1365, 0, none);
    add_row(7, 8191, 0, none);        // depth above max clamps to 5
    add_row(6, 4095, 0, none);
    add_row(0, 5, 0, none);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].depth != depth_reg) goto_depth(3'(rows[i].depth));
      send_beat(13'(rows[i].idx), i[0], rows[i].typed, rows[i].want);
    end

    // Random phases: mostly in-range indices, some beyond the triangle count.
    foreach (phase_depth[p]) begin
      goto_depth(3'(phase_depth[p]));
      count = 8 << (2 * ((depth_reg > 5) ? 5 : depth_reg));
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if (count >= 8192 || $urandom_range(0, 99) < 85)
          idx = 13'($urandom_range(0, count - 1));
        else
          idx = 13'($urandom_range(count, 8191));
        send_beat(idx, steady, 0, none);
      end
    end

    in_valid <= 1'b0;
    while (tri_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("** octahedron_sphere_tessellator: PASSED **");
    else
      $display("** octahedron_sphere_tessellator: FAILED **");
    $finish;
  end

endmodule
